[hw/rtl/hsv2rgb_pkg.sv]
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  localparam int unsigned DEF_FRACTION_BITS = 15;

  localparam int unsigned HUE_W   = 16;
  localparam int unsigned LEVEL_W = 16;

  // hue + 92*360 makes every 16-bit signed hue non-negative
  localparam int unsigned HUE_OFFSET = 33120;
  localparam int unsigned HUE_WRAP   = 360;

  // floor(2^22 / 360), quotient is exact or one low for u < 2^17
  localparam int unsigned HUE_RECIP = 11650;
  localparam int unsigned HUE_SHIFT = 22;

  // floor(2^24 / 60), quotient is exact or one low for n < 2^22
  localparam int unsigned DIV60_RECIP = 279620;
  localparam int unsigned DIV60_SHIFT = 24;
  localparam int unsigned SIXTY       = 60;

  localparam int unsigned NUM_STAGES = 8;

  typedef enum logic [2:0] {
    SECT_R_TO_Y = 3'd0,
    SECT_Y_TO_G = 3'd1,
    SECT_G_TO_C = 3'd2,
    SECT_C_TO_B = 3'd3,
    SECT_B_TO_M = 3'd4,
    SECT_M_TO_R = 3'd5
  } sector_t;

endpackage

[hw/rtl/hsv_to_rgb_converter.sv]
`timescale 1ns / 1ps
// pipeline: an accepted input transaction passes through every stage register before its output transaction
// throughput: one pixel per cycle while out_stall is low; a stage moves whenever the
// stage after it has room, so bubbles are squeezed out under output stall
// reset: rst clears all stage valid bits; data registers are not reset
module hsv_to_rgb_converter #(
  parameter int unsigned FRACTION_BITS = hsv2rgb_pkg::DEF_FRACTION_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]    hue_degrees,
  input  logic [hsv2rgb_pkg::LEVEL_W-1:0]  saturation_level,
  input  logic [hsv2rgb_pkg::LEVEL_W-1:0]  brightness_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [hsv2rgb_pkg::LEVEL_W-1:0]  red_level,
  output logic [hsv2rgb_pkg::LEVEL_W-1:0]  green_level,
  output logic [hsv2rgb_pkg::LEVEL_W-1:0]  blue_level
);
  import hsv2rgb_pkg::*;

  localparam logic [31:0] LevelOne = 32'(1) << FRACTION_BITS;

  logic [NUM_STAGES:1] vld;
  logic [NUM_STAGES:1] en;

  // stage 1: clamp, offset hue
  logic signed [17:0]  hue_ext;
  logic [LEVEL_W-1:0]  s_clamp, v_clamp;
  logic [16:0]         u1;
  logic [LEVEL_W-1:0]  s1, v1;

  // stage 2: chroma product, hue quotient estimate
  logic [31:0]         sv_prod;
  logic [30:0]         hue_prod;
  logic [LEVEL_W-1:0]  c2, v2;
  logic [8:0]          hq2;
  logic [16:0]         u2;

  // stage 3: wrapped hue
  logic [16:0]         hue_rem;
  logic [8:0]          hue3;
  logic [LEVEL_W-1:0]  c3, v3;

  // stage 4: sector and weight
  sector_t             sect_d, sector4;
  logic [6:0]          rem120;
  logic [5:0]          weight4;
  logic [LEVEL_W-1:0]  c4, m4;

  // stage 5: c * weight
  logic [21:0]         n5;
  sector_t             sector5;
  logic [LEVEL_W-1:0]  c5, m5;

  // stage 6: divide by sixty estimate
  logic [40:0]         div_prod;
  logic [LEVEL_W-1:0]  q6;
  logic [21:0]         n6;
  sector_t             sector6;
  logic [LEVEL_W-1:0]  c6, m6;

  // stage 7: corrected x
  logic [21:0]         rem60;
  logic [LEVEL_W-1:0]  x7, c7, m7;
  sector_t             sector7;

  // stage 8: outputs
  logic [LEVEL_W-1:0]  r_sel, g_sel, b_sel;
  logic [LEVEL_W-1:0]  red_q, green_q, blue_q;

  // a stage takes new data when it is empty or its content moves on
  always_comb begin
    en[NUM_STAGES] = !vld[NUM_STAGES] || !out_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall = !en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1
  assign hue_ext = 18'(signed'(hue_degrees)) + 18'(HUE_OFFSET);
  assign s_clamp = ({16'b0, saturation_level} > LevelOne) ? LEVEL_W'(LevelOne)
                                                          : saturation_level;
  assign v_clamp = ({16'b0, brightness_level} > LevelOne) ? LEVEL_W'(LevelOne)
                                                          : brightness_level;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      u1 <= hue_ext[16:0];
      s1 <= s_clamp;
      v1 <= v_clamp;
    end
  end

  // stage 2
  assign sv_prod  = 32'(s1) * 32'(v1);
  assign hue_prod = 31'(u1) * 31'(HUE_RECIP);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c2  <= LEVEL_W'(sv_prod >> FRACTION_BITS);
      v2  <= v1;
      hq2 <= hue_prod[30:HUE_SHIFT];
      u2  <= u1;
    end
  end

  // stage 3
  assign hue_rem = u2 - 17'(hq2) * 17'(HUE_WRAP);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      hue3 <= (hue_rem >= 17'(HUE_WRAP)) ? 9'(hue_rem - 17'(HUE_WRAP)) : 9'(hue_rem);
      c3   <= c2;
      v3   <= v2;
    end
  end

  // stage 4
  always_comb begin
    if (hue3 < 9'd60) begin
      sect_d = SECT_R_TO_Y;
      rem120 = 7'(hue3);
    end else if (hue3 < 9'd120) begin
      sect_d = SECT_Y_TO_G;
      rem120 = 7'(hue3);
    end else if (hue3 < 9'd180) begin
      sect_d = SECT_G_TO_C;
      rem120 = 7'(hue3 - 9'd120);
    end else if (hue3 < 9'd240) begin
      sect_d = SECT_C_TO_B;
      rem120 = 7'(hue3 - 9'd120);
    end else if (hue3 < 9'd300) begin
      sect_d = SECT_B_TO_M;
      rem120 = 7'(hue3 - 9'd240);
    end else begin
      sect_d = SECT_M_TO_R;
      rem120 = 7'(hue3 - 9'd240);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sector4 <= sect_d;
      // 60 - |rem120 - 60|
      weight4 <= (rem120 < 7'd60) ? 6'(rem120) : 6'(7'd120 - rem120);
      c4      <= c3;
      m4      <= v3 - c3;
    end
  end

  // stage 5
  always_ff @(posedge clk) begin
    if (en[5]) begin
      n5      <= 22'(c4) * 22'(weight4);
      sector5 <= sector4;
      c5      <= c4;
      m5      <= m4;
    end
  end

  // stage 6
  assign div_prod = 41'(n5) * 41'(DIV60_RECIP);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      q6      <= div_prod[DIV60_SHIFT +: LEVEL_W];
      n6      <= n5;
      sector6 <= sector5;
      c6      <= c5;
      m6      <= m5;
    end
  end

  // stage 7: the estimate is at most one low
  assign rem60 = n6 - 22'(q6) * 22'(SIXTY);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      x7      <= (rem60 >= 22'(SIXTY)) ? q6 + 1'b1 : q6;
      sector7 <= sector6;
      c7      <= c6;
      m7      <= m6;
    end
  end

  // stage 8
  always_comb begin
    case (sector7)
      SECT_R_TO_Y: begin r_sel = c7; g_sel = x7; b_sel = '0; end
      SECT_Y_TO_G: begin r_sel = x7; g_sel = c7; b_sel = '0; end
      SECT_G_TO_C: begin r_sel = '0; g_sel = c7; b_sel = x7; end
      SECT_C_TO_B: begin r_sel = '0; g_sel = x7; b_sel = c7; end
      SECT_B_TO_M: begin r_sel = x7; g_sel = '0; b_sel = c7; end
      default:     begin r_sel = c7; g_sel = '0; b_sel = x7; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      red_q   <= r_sel + m7;
      green_q <= g_sel + m7;
      blue_q  <= b_sel + m7;
    end
  end

  assign out_valid   = vld[NUM_STAGES];
  assign red_level   = red_q;
  assign green_level = green_q;
  assign blue_level  = blue_q;

  a_chroma_le_value: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (c3 <= v3))
    else $error("chroma exceeds value");

  a_hue_wrapped: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (hue3 < 9'(HUE_WRAP)) || !vld[3])
    else $error("hue not wrapped below 360");

  a_x_le_chroma: assert property (@(posedge clk) disable iff (rst)
    vld[7] |-> (x7 <= c7))
    else $error("x exceeds chroma");

  a_empty_front_accepts: assert property (@(posedge clk) disable iff (rst)
    !vld[1] |-> !in_stall)
    else $error("input stalled with empty first stage");

endmodule
